/* rtl/pbps_pkg.sv */
// ----------------------------------------------------------------------------
// Priority blink pattern sequencer package
// Shared sizes, command and step codes, and the blink pattern ROM.
// ----------------------------------------------------------------------------
package pbps_pkg;

    localparam int PATTERN_COUNT     = 8;
    localparam int MAX_PATTERN_STEPS = 6;
    localparam int HOLD_BITS         = 10;

    localparam int ROM_PATTERNS  = 8;
    localparam int ROM_WIDTH     = 6;
    localparam int PATTERN_LIMIT = (PATTERN_COUNT < ROM_PATTERNS) ? PATTERN_COUNT : ROM_PATTERNS;
    localparam int PIDX_W        = (PATTERN_LIMIT > 1) ? $clog2(PATTERN_LIMIT) : 1;
    localparam int WALK_LIMIT    = 1024;
    localparam int GUARD_W       = $clog2(WALK_LIMIT + 1);

    localparam logic [3:0] NO_PATTERN = 4'd8;
    localparam logic [3:0] STOP_MARK  = 4'd15;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [2:0] ST_STOP = 3'd0;
    localparam logic [2:0] ST_LOOP = 3'd1;
    localparam logic [2:0] ST_LVL0 = 3'd2;
    localparam logic [2:0] ST_LVL1 = 3'd3;
    localparam logic [2:0] ST_LVL2 = 3'd4;
    localparam logic [2:0] ST_LVL3 = 3'd5;
    localparam logic [2:0] ST_LVL4 = 3'd6;
    localparam logic [2:0] ST_COMM = 3'd7;

    typedef struct packed {
        logic [2:0]           kind;
        logic                 level;
        logic [HOLD_BITS-1:0] hold;
    } step_t;

    function automatic step_t make_step(input logic [2:0] kind, input logic level,
                                        input int hold);
        step_t r;
        r.kind  = kind;
        r.level = level;
        r.hold  = HOLD_BITS'(hold);
        return r;
    endfunction

    // Entries beyond a pattern's list read as stop steps.
    function automatic step_t rom_step(input logic [3:0] p, input logic [3:0] s);
        step_t r;
        r = make_step(ST_STOP, 1'b0, 0);
        if (s < MAX_PATTERN_STEPS && s < ROM_WIDTH) begin
            case (p)
                4'd0: begin
                    if (s == 4'd0) r = make_step(ST_LVL0, 1'b1, 200);
                    else if (s == 4'd1) r = make_step(ST_LOOP, 1'b0, 0);
                end
                4'd1: begin
                    if (s == 4'd0) r = make_step(ST_LVL4, 1'b1, 200);
                    else if (s == 4'd1) r = make_step(ST_LOOP, 1'b0, 0);
                end
                4'd2, 4'd3, 4'd4: begin
                    case (s)
                        4'd0: r = make_step(ST_LVL0, 1'b1, (p == 4'd3) ? 200 : 300);
                        4'd1: r = make_step(ST_LVL1, 1'b1,
                                            (p == 4'd2) ? 300 : (p == 4'd3) ? 200 : 250);
                        4'd2: r = make_step(ST_LVL2, 1'b1, (p == 4'd2) ? 300 : 200);
                        4'd3: r = make_step(ST_LVL3, 1'b1,
                                            (p == 4'd2) ? 300 : (p == 4'd3) ? 200 : 150);
                        4'd4: r = make_step(ST_LVL4, 1'b1,
                                            (p == 4'd2) ? 300 : (p == 4'd3) ? 200 : 100);
                        4'd5: r = make_step(ST_LOOP, 1'b0, 0);
                        default: r = make_step(ST_STOP, 1'b0, 0);
                    endcase
                end
                4'd5: begin
                    if (s == 4'd0) r = make_step(ST_COMM, 1'b0, 500);
                    else if (s == 4'd1) r = make_step(ST_LOOP, 1'b0, 0);
                end
                4'd6: begin
                    if (s == 4'd0) r = make_step(ST_COMM, 1'b1, 500);
                    else if (s == 4'd1) r = make_step(ST_LOOP, 1'b0, 0);
                end
                4'd7: begin
                    if (s == 4'd0) r = make_step(ST_COMM, 1'b1, 200);
                    else if (s == 4'd1) r = make_step(ST_COMM, 1'b0, 200);
                    else if (s == 4'd2) r = make_step(ST_LOOP, 1'b0, 0);
                end
                default: r = make_step(ST_STOP, 1'b0, 0);
            endcase
        end
        return r;
    endfunction

endpackage

/* rtl/pbps_prio_pick.sv */
// ----------------------------------------------------------------------------
// Priority pattern picker
// Returns the lowest-numbered pattern that is not stopped, or the none code.
// ----------------------------------------------------------------------------
module pbps_prio_pick (
    input  logic [pbps_pkg::PATTERN_LIMIT-1:0] live,
    output logic [3:0]                         pick
);
    import pbps_pkg::*;

    always_comb begin
        pick = NO_PATTERN;
        for (int i = PATTERN_LIMIT - 1; i >= 0; i--) begin
            if (live[i]) begin
                pick = 4'(i);
            end
        end
    end

endmodule

/* rtl/priority_blink_pattern_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Priority blink pattern sequencer
// Runs eight ROM blink patterns by priority and drives the bar and comm
// segments from one-millisecond ticks and start/stop commands.
// ----------------------------------------------------------------------------
// Each transaction on the s_ channel is a tick, a start or a stop command and
// produces exactly one m_ transaction that reports the segments, the active
// pattern and whether the hold countdown runs. A small sequencer handles one
// transaction at a time. A tick that only counts down passes through the command
// and done states; a start or stop command also passes the choose state. Each ROM
// step walked passes the walk state, and a stop step also passes the rescan state
// for a new priority pick. A walk that finds no active pattern ends without a step.
// With the fixed ROM a walk visits at most two steps. The done state waits until
// the output register is free. A runaway walk is cut off after 1024 steps.
module priority_blink_pattern_sequencer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [2:0] s_pattern_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_bar_one,
    output logic       m_bar_two,
    output logic       m_bar_three,
    output logic       m_bar_four,
    output logic       m_bar_five,
    output logic       m_comm_mark,
    output logic [3:0] m_active_pattern,
    output logic       m_hold_running
);
    import pbps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CMD    = 3'd1;
    localparam logic [2:0] S_CHOOSE = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_RESCAN = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [1:0]           cmd_reg;
    logic [2:0]           idx_reg;
    logic [3:0]           step_pos_reg [PATTERN_LIMIT];
    logic [3:0]           step_pos_next [PATTERN_LIMIT];
    logic [3:0]           cur_reg, cur_next;
    logic [HOLD_BITS-1:0] hold_reg, hold_next;
    logic                 timer_reg, timer_next;
    logic [5:0]           seg_reg, seg_next;
    logic [GUARD_W-1:0]   guard_reg, guard_next;
    logic                 m_valid_reg;
    logic [5:0]           out_seg_reg;
    logic [3:0]           out_pat_reg;
    logic                 out_run_reg;
    logic                 m_load;

    logic [PATTERN_LIMIT-1:0] live;
    logic [3:0]               pick;
    logic [PIDX_W-1:0]        walk_idx;
    logic [PIDX_W-1:0]        cmd_idx;
    logic [3:0]               walk_pos;
    logic                     walk_ok;
    step_t                    walk_step;

    always_comb begin
        for (int i = 0; i < PATTERN_LIMIT; i++) begin
            live[i] = (step_pos_reg[i] != STOP_MARK);
        end
    end

    pbps_prio_pick u_pick (
        .live (live),
        .pick (pick)
    );

    assign walk_idx  = cur_reg[PIDX_W-1:0];
    assign cmd_idx   = PIDX_W'(idx_reg);
    assign walk_ok   = (cur_reg < 4'(PATTERN_LIMIT));
    assign walk_pos  = step_pos_reg[walk_idx];
    assign walk_step = rom_step(cur_reg, walk_pos);

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        step_pos_next = step_pos_reg;
        cur_next      = cur_reg;
        hold_next     = hold_reg;
        timer_next    = timer_reg;
        seg_next      = seg_reg;
        guard_next    = guard_reg;
        m_load        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CMD;
                end
            end
            S_CMD: begin
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_TICK: begin
                        if (timer_reg) begin
                            if (hold_reg > HOLD_BITS'(1)) begin
                                hold_next = hold_reg - HOLD_BITS'(1);
                            end else begin
                                hold_next  = '0;
                                timer_next = 1'b0;
                                guard_next = '0;
                                state_next = S_WALK;
                            end
                        end
                    end
                    CMD_START, CMD_STOP: begin
                        if ({1'b0, idx_reg} < 4'(PATTERN_LIMIT)) begin
                            step_pos_next[cmd_idx] = (cmd_reg == CMD_START) ? 4'd0 : STOP_MARK;
                            state_next = S_CHOOSE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_CHOOSE: begin
                // The walk runs at once only for the commanded pattern.
                cur_next = pick;
                if (pick == {1'b0, idx_reg}) begin
                    guard_next = '0;
                    state_next = S_WALK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RESCAN: begin
                cur_next   = pick;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (guard_reg == GUARD_W'(WALK_LIMIT)) begin
                    timer_next = 1'b0;
                    hold_next  = '0;
                    state_next = S_DONE;
                end else if (!walk_ok) begin
                    state_next = S_DONE;
                end else begin
                    guard_next = guard_reg + GUARD_W'(1);
                    step_pos_next[walk_idx] = walk_pos + 4'd1;
                    case (walk_step.kind)
                        ST_LOOP: step_pos_next[walk_idx] = 4'd0;
                        ST_STOP: begin
                            step_pos_next[walk_idx] = STOP_MARK;
                            state_next = S_RESCAN;
                        end
                        ST_LVL0: seg_next = {seg_reg[5], 5'b00001};
                        ST_LVL1: seg_next = seg_reg | 6'b000010;
                        ST_LVL2: seg_next = seg_reg | 6'b000100;
                        ST_LVL3: seg_next = seg_reg | 6'b001000;
                        ST_LVL4: seg_next = seg_reg | 6'b011111;
                        default: seg_next = {walk_step.level, seg_reg[4:0]};
                    endcase
                    // A display step with a nonzero hold ends the walk.
                    if (walk_step.kind != ST_LOOP && walk_step.kind != ST_STOP &&
                        walk_step.hold != '0) begin
                        hold_next  = walk_step.hold;
                        timer_next = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_reg     <= NO_PATTERN;
            hold_reg    <= '0;
            timer_reg   <= 1'b0;
            seg_reg     <= '0;
            guard_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < PATTERN_LIMIT; i++) begin
                step_pos_reg[i] <= STOP_MARK;
            end
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            hold_reg     <= hold_next;
            timer_reg    <= timer_next;
            seg_reg      <= seg_next;
            guard_reg    <= guard_next;
            step_pos_reg <= step_pos_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_command;
            idx_reg <= s_pattern_index;
        end
        if (m_load) begin
            out_seg_reg <= seg_reg;
            out_pat_reg <= cur_reg;
            out_run_reg <= timer_reg;
        end
    end

    assign m_bar_one        = out_seg_reg[0];
    assign m_bar_two        = out_seg_reg[1];
    assign m_bar_three      = out_seg_reg[2];
    assign m_bar_four       = out_seg_reg[3];
    assign m_bar_five       = out_seg_reg[4];
    assign m_comm_mark      = out_seg_reg[5];
    assign m_active_pattern = out_pat_reg;
    assign m_hold_running   = out_run_reg;

    // A running countdown always has time left.
    a_timer_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_reg |-> hold_reg != '0)
        else $error("countdown running with zero hold");

    // The walk guard never passes its bound.
    a_guard_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> guard_reg <= GUARD_W'(WALK_LIMIT))
        else $error("walk guard out of range");

    // A result carries the state held when it was loaded.
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_load |=> m_valid_reg && out_pat_reg == $past(cur_reg) &&
                   out_run_reg == $past(timer_reg) && out_seg_reg == $past(seg_reg))
        else $error("result does not match sequencer state");

    // An accepted transaction moves the sequencer out of idle.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_CMD && !s_ready)
        else $error("sequencer did not start on accepted transaction");

endmodule
